// File: hw/rtl/blr_pkg.sv
// Shared widths, constants and the line command type for the line rasteriser.
`timescale 1ns / 1ps
package blr_pkg;

  localparam int COORD_W         = 6;
  localparam int ADDR_W          = 12;
  localparam int COLOR_W         = 32;
  localparam int PITCH_W         = 7;
  localparam int ERR_W           = COORD_W + 2;
  localparam int SCREEN_SIZE_DEF = 64;
  localparam int CMDQ_DEPTH_DEF  = 2;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               y_dec;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

endpackage

// File: hw/rtl/blr_front.sv
// Front end: saturates endpoints, classifies the line and builds the walk command.
`timescale 1ns / 1ps
module blr_front
  import blr_pkg::*;
#(
  parameter int SCREEN_SIZE = SCREEN_SIZE_DEF
) (
  input  logic [COORD_W-1:0] start_x,
  input  logic [COORD_W-1:0] start_y,
  input  logic [COORD_W-1:0] end_x,
  input  logic [COORD_W-1:0] end_y,
  input  logic [COLOR_W-1:0] line_color,
  output line_cmd_t          cmd
);

  localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(SCREEN_SIZE - 1);

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] adx, ady;
  logic [COORD_W-1:0] p0, q0, p1, q1;
  logic               steep;

  always_comb begin
    ax = (start_x > MaxCoord) ? MaxCoord : start_x;
    ay = (start_y > MaxCoord) ? MaxCoord : start_y;
    bx = (end_x   > MaxCoord) ? MaxCoord : end_x;
    by = (end_y   > MaxCoord) ? MaxCoord : end_y;
    adx = (ax > bx) ? (ax - bx) : (bx - ax);
    ady = (ay > by) ? (ay - by) : (by - ay);
    steep = ady > adx;
    p0 = steep ? ay : ax;
    q0 = steep ? ax : ay;
    p1 = steep ? by : bx;
    q1 = steep ? bx : by;
    if (p0 > p1) begin
      cmd.x_start = p1;
      cmd.x_end   = p0;
      cmd.y_start = q1;
      cmd.y_dec   = q1 > q0;
    end else begin
      cmd.x_start = p0;
      cmd.x_end   = p1;
      cmd.y_start = q0;
      cmd.y_dec   = q0 > q1;
    end
    cmd.dx    = steep ? ady : adx;
    cmd.dy    = steep ? adx : ady;
    cmd.steep = steep;
    cmd.color = line_color;
  end

endmodule

// File: hw/rtl/blr_cmd_queue.sv
// Short command queue between the front end and the walker.
`timescale 1ns / 1ps
module blr_cmd_queue
  import blr_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  line_cmd_t push_cmd,
  output logic      full,
  output logic      not_empty,
  input  logic      pop,
  output line_cmd_t head_cmd
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  line_cmd_t           slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = count_r == CntW'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/blr_walker.sv
// Back end: Bresenham walk, one pixel per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
module blr_walker
  import blr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PITCH_W-1:0] row_pitch,
  input  logic               cq_not_empty,
  input  line_cmd_t          cq_cmd,
  output logic               cq_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_last_pixel
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                     state_r, state_nxt;
  logic [COORD_W-1:0]       x_r, xend_r, y_r, dx_r, dy_r;
  logic                     ydec_r, steep_r;
  logic [COLOR_W-1:0]       color_r;
  logic signed [ERR_W-1:0]  err_r, err_sub, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]       px_r, py_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     last_r;
  logic [COLOR_W-1:0]       ocolor_r;
  logic                     out_free, step;
  logic [COORD_W-1:0]       px, py;
  logic [COORD_W+PITCH_W-1:0] prod;
  logic [ADDR_W-1:0]        addr;

  assign out_free = !out_valid_r || !out_stall;
  assign cq_pop   = (state_r == ST_IDLE) && cq_not_empty;
  assign step     = (state_r == ST_WALK) && out_free;

  always_comb begin
    px      = steep_r ? y_r : x_r;
    py      = steep_r ? x_r : y_r;
    prod    = py * row_pitch;
    addr    = prod[ADDR_W-1:0] + ADDR_W'(px);
    err_sub = err_r - ERR_W'(dy_r);
    err_nxt = (err_sub < 0) ? err_sub + ERR_W'(dx_r) : err_sub;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cq_not_empty) state_nxt = ST_WALK;
      ST_WALK: if (step && x_r == xend_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      x_r     <= cq_cmd.x_start;
      xend_r  <= cq_cmd.x_end;
      y_r     <= cq_cmd.y_start;
      dx_r    <= cq_cmd.dx;
      dy_r    <= cq_cmd.dy;
      ydec_r  <= cq_cmd.y_dec;
      steep_r <= cq_cmd.steep;
      color_r <= cq_cmd.color;
      err_r   <= ERR_W'(cq_cmd.dx >> 1);
    end else if (step) begin
      x_r   <= x_r + 1'b1;
      err_r <= err_nxt;
      if (err_sub < 0) begin
        y_r <= ydec_r ? y_r - 1'b1 : y_r + 1'b1;
      end
    end
    if (step) begin
      px_r     <= px;
      py_r     <= py;
      addr_r   <= addr;
      last_r   <= x_r == xend_r;
      ocolor_r <= color_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = ocolor_r;
  assign out_last_pixel    = last_r;

  a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> x_r <= xend_r)
    else $error("walker stepped beyond the line end");

  a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> err_r >= 0)
    else $error("error term negative during walk");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && x_r == xend_r) |=> state_r == ST_IDLE)
    else $error("walker did not finish after last pixel");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |=> state_r == ST_WALK)
    else $error("command popped without starting a walk");

endmodule

// File: hw/rtl/bresenham_line_rasterizer_top.sv
// An accepted command is written into the command queue, then loaded from it into the walker
// registers; the walker then emits one pixel per cycle on the major axis into its output
// register, whenever out_stall does not hold the output.
// The command queue (two entries by default) lets the next lines be accepted during a walk.
// Reset (rst_n low, synchronous): queue and walker empty, row_pitch returns to 64.
// Top level of the line rasteriser.
`timescale 1ns / 1ps
module bresenham_line_rasterizer_top
  import blr_pkg::*;
#(
  parameter int SCREEN_SIZE = SCREEN_SIZE_DEF,
  parameter int CMDQ_DEPTH  = CMDQ_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_start_x,
  input  logic [COORD_W-1:0] in_start_y,
  input  logic [COORD_W-1:0] in_end_x,
  input  logic [COORD_W-1:0] in_end_y,
  input  logic [COLOR_W-1:0] in_line_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_last_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PITCH_W-1:0] cfg_data
);

  logic [PITCH_W-1:0] row_pitch_r;
  line_cmd_t          front_cmd, head_cmd;
  logic               cq_full, cq_not_empty, cq_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = cq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r <= PITCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_pitch_r <= cfg_data;
    end
  end

  blr_front #(
    .SCREEN_SIZE(SCREEN_SIZE)
  ) u_front (
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .line_color(in_line_color),
    .cmd       (front_cmd)
  );

  blr_cmd_queue #(
    .DEPTH(CMDQ_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_cmd (front_cmd),
    .full     (cq_full),
    .not_empty(cq_not_empty),
    .pop      (cq_pop),
    .head_cmd (head_cmd)
  );

  blr_walker u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .row_pitch        (row_pitch_r),
    .cq_not_empty     (cq_not_empty),
    .cq_cmd           (head_cmd),
    .cq_pop           (cq_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
